### rtl/shortest_span_of_mode_defines.svh
// Assertion macros shared by the shortest_span_of_mode RTL.
`ifndef SHORTEST_SPAN_OF_MODE_DEFINES_SVH
`define SHORTEST_SPAN_OF_MODE_DEFINES_SVH

// Same-cycle implication, sampled on clk and silenced during reset.
`define SSM_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, sampled on clk and silenced during reset.
`define SSM_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

### rtl/ssm_pkg.sv
// Package: sizes, table entry layout and control structs for shortest_span_of_mode.
package ssm_pkg;

    // Field widths fixed by the ports
    localparam int VALUE_W = 10;
    localparam int OUT_W   = 13;

    // Table and array sizing
    localparam int VALUE_RANGE = 1024;
    localparam int SLOT_W      = $clog2(VALUE_RANGE);
    localparam int MAX_LENGTH  = 4096;
    localparam int POS_W       = $clog2(MAX_LENGTH + 1);
    localparam int IDX_W       = $clog2(MAX_LENGTH);

    // Epoch tag: zero marks an entry as stale, live arrays use 1 .. EPOCH_MAX
    localparam int EPOCH_W = 8;
    localparam logic [EPOCH_W-1:0] EPOCH_FIRST = EPOCH_W'(1);
    localparam logic [EPOCH_W-1:0] EPOCH_MAX   = {EPOCH_W{1'b1}};

    typedef logic [EPOCH_W-1:0] epoch_t;

    // One table word: tag, occurrence count, index of first occurrence
    typedef struct packed {
        epoch_t             tag;
        logic [POS_W-1:0]   count;
        logic [IDX_W-1:0]   first;
    } entry_t;

    localparam int ENTRY_W = $bits(entry_t);

    // Sweep/epoch control handed to the datapath
    typedef struct packed {
        logic               busy;
        logic [SLOT_W-1:0]  addr;
        epoch_t             epoch;
        logic               last_epoch;
    } sweep_t;

    // Result of one array
    typedef struct packed {
        logic [OUT_W-1:0]   span;
        logic [OUT_W-1:0]   degree;
        logic               overflow;
    } result_t;

    // Sweep sequencer states
    typedef enum logic [1:0] {
        ST_SWEEP = 2'b01,
        ST_RUN   = 2'b10
    } sweep_state_t;

endpackage

### rtl/ssm_ifs.sv
// Interfaces: element input channel and result output channel.
interface ssm_element_if;
    logic                         valid;
    logic                         ready;
    logic [ssm_pkg::VALUE_W-1:0]  value;
    logic                         last;

    modport source (output valid, value, last, input ready);
    modport sink   (input valid, value, last, output ready);
endinterface

interface ssm_result_if;
    logic                         valid;
    logic                         ready;
    logic [ssm_pkg::OUT_W-1:0]    shortest_length;
    logic [ssm_pkg::OUT_W-1:0]    degree;
    logic                         overflow;

    modport source (output valid, shortest_length, degree, overflow, input ready);
    modport sink   (input valid, shortest_length, degree, overflow, output ready);
endinterface

### rtl/ssm_ram.sv
// Generic simple dual-port RAM with one write port and a registered read port.
module ssm_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // Write, and read old contents on a same-address collision
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

### rtl/ssm_epoch.sv
// Epoch counter and table sweep that retires stale entries before the tag wraps.
`include "shortest_span_of_mode_defines.svh"

module ssm_epoch (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             advance,
    output ssm_pkg::sweep_t  sweep
);

    ssm_pkg::sweep_state_t           state_reg, state_next;
    logic [ssm_pkg::SLOT_W-1:0]      addr_reg, addr_next;
    ssm_pkg::epoch_t                 epoch_reg, epoch_next;

    // Step the sweep address, or move to the next epoch at each array end and start a sweep after the top epoch
    always_comb
    begin
        state_next = state_reg;
        addr_next  = addr_reg;
        epoch_next = epoch_reg;
        unique case (state_reg)
            ssm_pkg::ST_SWEEP:
            begin
                addr_next = addr_reg + 1'b1;
                if (addr_reg == {ssm_pkg::SLOT_W{1'b1}})
                begin
                    state_next = ssm_pkg::ST_RUN;
                    epoch_next = ssm_pkg::EPOCH_FIRST;
                end
            end
            ssm_pkg::ST_RUN:
            begin
                if (advance)
                begin
                    if (epoch_reg == ssm_pkg::EPOCH_MAX)
                    begin
                        state_next = ssm_pkg::ST_SWEEP;
                        addr_next  = '0;
                    end
                    else
                    begin
                        epoch_next = epoch_reg + 1'b1;
                    end
                end
            end
            default:
            begin
                state_next = ssm_pkg::ST_SWEEP;
                addr_next  = '0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ssm_pkg::ST_SWEEP;
            addr_reg  <= '0;
            epoch_reg <= ssm_pkg::EPOCH_FIRST;
        end
        else
        begin
            state_reg <= state_next;
            addr_reg  <= addr_next;
            epoch_reg <= epoch_next;
        end
    end

    assign sweep.busy       = (state_reg == ssm_pkg::ST_SWEEP);
    assign sweep.addr       = addr_reg;
    assign sweep.epoch      = epoch_reg;
    assign sweep.last_epoch = (epoch_reg == ssm_pkg::EPOCH_MAX);

    // A live epoch never uses the stale tag
    `SSM_ASSERT_NOW(a_epoch_live, state_reg == ssm_pkg::ST_RUN, epoch_reg != '0,
        "live epoch carries the stale tag")
    // No array may end while the table is being swept
    `SSM_ASSERT_NOW(a_no_advance_in_sweep, state_reg == ssm_pkg::ST_SWEEP, !advance,
        "array ended during table sweep")
    // Wrapping from the top epoch always starts a sweep
    `SSM_ASSERT_NEXT(a_wrap_sweeps,
        state_reg == ssm_pkg::ST_RUN && advance && epoch_reg == ssm_pkg::EPOCH_MAX,
        state_reg == ssm_pkg::ST_SWEEP && addr_reg == '0,
        "epoch wrapped without a sweep")

endmodule

### rtl/ssm_tally.sv
// Per-element update: count and first index of the value, running best and position.
`include "shortest_span_of_mode_defines.svh"

module ssm_tally (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              go,
    input  logic              last,
    input  ssm_pkg::entry_t   word,
    input  ssm_pkg::epoch_t   epoch,
    output logic              wr_en,
    output ssm_pkg::entry_t   wr_word,
    output ssm_pkg::result_t  result
);

    logic [ssm_pkg::POS_W-1:0] position_reg, position_next;
    logic [ssm_pkg::POS_W-1:0] best_count_reg, best_count_next;
    logic [ssm_pkg::POS_W-1:0] best_span_reg, best_span_next;
    logic                      overflow_reg, overflow_next;

    logic                      in_range;
    logic                      hit;
    logic [ssm_pkg::POS_W-1:0] count_upd;
    logic [ssm_pkg::IDX_W-1:0] first_upd;
    logic [ssm_pkg::POS_W-1:0] span;
    logic                      better;
    logic [ssm_pkg::POS_W-1:0] nb_count;
    logic [ssm_pkg::POS_W-1:0] nb_span;
    logic                      nb_overflow;

    // Count the value and measure its span up to this element
    always_comb
    begin
        in_range  = (position_reg < ssm_pkg::POS_W'(ssm_pkg::MAX_LENGTH));
        hit       = (word.tag == epoch);
        count_upd = hit ? (word.count + 1'b1) : ssm_pkg::POS_W'(1);
        first_upd = hit ? word.first : position_reg[ssm_pkg::IDX_W-1:0];
        span      = position_reg - ssm_pkg::POS_W'(first_upd) + 1'b1;
        better    = (count_upd > best_count_reg) ||
                    ((count_upd == best_count_reg) && (span < best_span_reg));
        nb_count    = (in_range && better) ? count_upd : best_count_reg;
        nb_span     = (in_range && better) ? span : best_span_reg;
        nb_overflow = overflow_reg || !in_range;
    end

    assign wr_en         = go && in_range;
    assign wr_word.tag   = epoch;
    assign wr_word.count = count_upd;
    assign wr_word.first = first_upd;

    assign result.span     = ssm_pkg::OUT_W'(nb_span);
    assign result.degree   = ssm_pkg::OUT_W'(nb_count);
    assign result.overflow = nb_overflow;

    // Advance the running state, clear it at the end of an array
    always_comb
    begin
        position_next   = position_reg;
        best_count_next = best_count_reg;
        best_span_next  = best_span_reg;
        overflow_next   = overflow_reg;
        if (go)
        begin
            if (last)
            begin
                position_next   = '0;
                best_count_next = '0;
                best_span_next  = '0;
                overflow_next   = 1'b0;
            end
            else
            begin
                position_next   = in_range ? (position_reg + 1'b1) : position_reg;
                best_count_next = nb_count;
                best_span_next  = nb_span;
                overflow_next   = nb_overflow;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            position_reg   <= '0;
            best_count_reg <= '0;
            best_span_reg  <= '0;
            overflow_reg   <= 1'b0;
        end
        else
        begin
            position_reg   <= position_next;
            best_count_reg <= best_count_next;
            best_span_reg  <= best_span_next;
            overflow_reg   <= overflow_next;
        end
    end

    // Every finished array has counted at least its first element
    `SSM_ASSERT_NOW(a_degree_nonzero, go && last, nb_count != '0,
        "array finished with zero degree")
    // Position saturates and never passes the maximum length
    `SSM_ASSERT_NOW(a_pos_bound, 1'b1,
        position_reg <= ssm_pkg::POS_W'(ssm_pkg::MAX_LENGTH),
        "position beyond maximum length")
    // A saturated array is flagged from then on
    `SSM_ASSERT_NEXT(a_sat_flags, go && !last && !in_range, overflow_reg,
        "saturation not flagged")

endmodule

### rtl/shortest_span_of_mode.sv
// Top level: array degree and shortest span of the mode, one element per cycle when not stalled.
//
// Accepts one array element per clock cycle unless the sweep or a stalled
// update stage lowers element.ready, and returns one result per array from
// the output register: the table entry is read from a 1024-entry RAM on
// acceptance, then updated and written back in the update stage, with the
// write forwarded to a following element of the same value. Entries carry an
// 8-bit array epoch tag instead of being cleared per array; after reset, and
// after every 255th array, the block sweeps all 1024 entries with element.ready
// low. Arrays over 4096 elements count only their first 4096 and set overflow.
`include "shortest_span_of_mode_defines.svh"

module shortest_span_of_mode (
    input  logic          clk,
    input  logic          rst_n,
    ssm_element_if.sink   element,
    ssm_result_if.source  result
);

    ssm_pkg::sweep_t             sweep;
    ssm_pkg::entry_t             ram_rdata;
    ssm_pkg::entry_t             ram_wdata;
    logic [ssm_pkg::SLOT_W-1:0]  ram_waddr;
    logic                        ram_we;

    logic                        accept;
    logic [ssm_pkg::SLOT_W-1:0]  slot;

    logic                        s1_valid_reg, s1_valid_next;
    logic                        s1_last_reg;
    logic [ssm_pkg::SLOT_W-1:0]  s1_slot_reg;
    logic                        s1_go;

    logic                        fwd_valid_reg;
    ssm_pkg::entry_t             fwd_word_reg;
    ssm_pkg::entry_t             s1_word;

    logic                        tally_wr_en;
    ssm_pkg::entry_t             tally_wr_word;
    ssm_pkg::result_t            tally_result;

    logic                        res_valid_reg, res_valid_next;
    ssm_pkg::result_t            res_reg;

    // Table slot of the incoming element
    assign slot   = ssm_pkg::SLOT_W'(element.value % ssm_pkg::VALUE_RANGE);
    assign accept = element.valid && element.ready;

    // Update stage advances unless a last element finds the result register full and result.ready low
    assign s1_go = s1_valid_reg && (!s1_last_reg || !res_valid_reg || result.ready);

    // Take a transfer unless sweeping, a wrapping array end is in flight, or the update stage is stalled
    assign element.ready = !sweep.busy &&
                           !(sweep.last_epoch && s1_valid_reg && s1_last_reg) &&
                           (!s1_valid_reg || s1_go);

    ssm_epoch u_epoch (
        .clk     (clk),
        .rst_n   (rst_n),
        .advance (s1_go && s1_last_reg),
        .sweep   (sweep)
    );

    // Sweep owns the write port while busy
    always_comb
    begin
        if (sweep.busy)
        begin
            ram_we    = 1'b1;
            ram_waddr = sweep.addr;
            ram_wdata = '0;
        end
        else
        begin
            ram_we    = tally_wr_en;
            ram_waddr = s1_slot_reg;
            ram_wdata = tally_wr_word;
        end
    end

    ssm_ram #(
        .WIDTH (ssm_pkg::ENTRY_W),
        .DEPTH (ssm_pkg::VALUE_RANGE)
    ) u_table (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (accept),
        .raddr (slot),
        .rdata (ram_rdata)
    );

    // Use the forwarded word when the previous element wrote the same slot
    assign s1_word = fwd_valid_reg ? fwd_word_reg : ram_rdata;

    ssm_tally u_tally (
        .clk     (clk),
        .rst_n   (rst_n),
        .go      (s1_go),
        .last    (s1_last_reg),
        .word    (s1_word),
        .epoch   (sweep.epoch),
        .wr_en   (tally_wr_en),
        .wr_word (tally_wr_word),
        .result  (tally_result)
    );

    // Hold the update stage occupancy
    always_comb
    begin
        s1_valid_next = s1_valid_reg;
        if (accept)
        begin
            s1_valid_next = 1'b1;
        end
        else if (s1_go)
        begin
            s1_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            fwd_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg <= s1_valid_next;
            if (accept)
            begin
                fwd_valid_reg <= tally_wr_en && (s1_slot_reg == slot);
            end
            else if (s1_go)
            begin
                fwd_valid_reg <= 1'b0;
            end
        end
    end

    // Payload of the update stage and the forwarding register
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_slot_reg  <= slot;
            s1_last_reg  <= element.last;
            fwd_word_reg <= tally_wr_word;
        end
    end

    // Output register: load on an array end, drop on a transfer
    always_comb
    begin
        res_valid_next = res_valid_reg;
        if (s1_go && s1_last_reg)
        begin
            res_valid_next = 1'b1;
        end
        else if (result.ready)
        begin
            res_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            res_valid_reg <= 1'b0;
        end
        else
        begin
            res_valid_reg <= res_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s1_go && s1_last_reg)
        begin
            res_reg <= tally_result;
        end
    end

    assign result.valid           = res_valid_reg;
    assign result.shortest_length = res_reg.span;
    assign result.degree          = res_reg.degree;
    assign result.overflow        = res_reg.overflow;

    // No element enters while the table is swept
    `SSM_ASSERT_NOW(a_no_accept_in_sweep, sweep.busy, !element.ready,
        "element accepted during table sweep")
    // Forwarding only ever serves an occupied update stage
    `SSM_ASSERT_NOW(a_fwd_occupied, fwd_valid_reg, s1_valid_reg,
        "forwarding armed with empty update stage")
    // An array end always presents a result next cycle
    `SSM_ASSERT_NEXT(a_result_follows, s1_go && s1_last_reg, result.valid,
        "array end produced no result")

endmodule

### sim/mode_span_check.sv
// Checker for shortest_span_of_mode: predicts each array's degree and span and compares results.
module mode_span_check (
    input  logic   clk,
    input  logic   rst_n,
    ssm_element_if element,
    ssm_result_if  result,
    output int     fail_count,
    output int     pending
);
    timeunit 1ns;
    timeprecision 1ps;

    // Per-value tallies of the array in flight
    logic [ssm_pkg::OUT_W-1:0] seen_count [ssm_pkg::VALUE_RANGE];
    logic [ssm_pkg::IDX_W-1:0] seen_first [ssm_pkg::VALUE_RANGE];
    logic                      seen_live  [ssm_pkg::VALUE_RANGE];

    logic [ssm_pkg::POS_W-1:0] next_pos;
    logic [ssm_pkg::OUT_W-1:0] best_count;
    logic [ssm_pkg::OUT_W-1:0] best_span;
    logic                      too_long;

    ssm_pkg::result_t          expected_q [$];
    ssm_pkg::result_t          want;

    initial
    begin
        fail_count = 0;
        pending    = 0;
    end

    task automatic report_mismatch(input string msg);
        $display("[%0t] mismatch: %s", $realtime, msg);
        fail_count++;
    endtask

    // Drop every tally and the running best
    task automatic clear_array();
        for (int i = 0; i < ssm_pkg::VALUE_RANGE; i++)
        begin
            seen_live[i] = 1'b0;
        end
        next_pos   = '0;
        best_count = '0;
        best_span  = '0;
        too_long   = 1'b0;
    endtask

    // Fold one element into the tallies; queue the array's result on its last element
    task automatic tally_element(input logic [ssm_pkg::VALUE_W-1:0] v, input logic is_last);
        int unsigned               slot;
        logic [ssm_pkg::OUT_W-1:0] cnt;
        logic [ssm_pkg::OUT_W-1:0] span;
        ssm_pkg::result_t          res;

        slot = v % ssm_pkg::VALUE_RANGE;
        if (next_pos >= ssm_pkg::MAX_LENGTH)
        begin
            too_long = 1'b1;
        end
        else
        begin
            if (seen_live[slot])
            begin
                cnt = seen_count[slot] + 1'b1;
            end
            else
            begin
                cnt              = ssm_pkg::OUT_W'(1);
                seen_first[slot] = ssm_pkg::IDX_W'(next_pos);
                seen_live[slot]  = 1'b1;
            end
            seen_count[slot] = cnt;
            span = ssm_pkg::OUT_W'(next_pos - seen_first[slot] + 1);
            // Higher count wins; on equal counts the shorter span wins
            if (cnt > best_count || (cnt == best_count && span < best_span))
            begin
                best_count = cnt;
                best_span  = span;
            end
            next_pos = next_pos + 1'b1;
        end

        if (is_last)
        begin
            res.span     = best_span;
            res.degree   = best_count;
            res.overflow = too_long;
            expected_q.push_back(res);
            clear_array();
        end
    endtask

    // Compare result transfers, then predict from element transfers
    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            clear_array();
        end
        else
        begin
            if (result.valid && result.ready)
            begin
                if (expected_q.size() == 0)
                begin
                    report_mismatch($sformatf("result with none expected: span %0d degree %0d",
                                              result.shortest_length, result.degree));
                end
                else
                begin
                    want = expected_q.pop_front();
                    if (result.shortest_length !== want.span)
                    begin
                        report_mismatch($sformatf("shortest_length %0d, expected %0d",
                                                  result.shortest_length, want.span));
                    end
                    if (result.degree !== want.degree)
                    begin
                        report_mismatch($sformatf("degree %0d, expected %0d",
                                                  result.degree, want.degree));
                    end
                    if (result.overflow !== want.overflow)
                    begin
                        report_mismatch($sformatf("overflow %0b, expected %0b",
                                                  result.overflow, want.overflow));
                    end
                end
            end
            if (element.valid && element.ready)
            begin
                tally_element(element.value, element.last);
            end
        end
        pending = expected_q.size();
    end

endmodule

### sim/tb_top.sv
// Testbench top for shortest_span_of_mode: clock, reset, array stimulus and the verdict.
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int CLOCK_LIMIT = 1_000_000;

    logic clk = 1'b0;
    logic rst_n;

    int   fail_count;
    int   pending;
    int   cycle_count = 0;
    int   items_sent  = 0;
    int   ready_hold  = 0;
    int   tail_target;
    bit   stalls_on;

    ssm_element_if element_ch ();
    ssm_result_if  result_ch ();

    shortest_span_of_mode dut (
        .clk     (clk),
        .rst_n   (rst_n),
        .element (element_ch),
        .result  (result_ch)
    );

    mode_span_check span_check (
        .clk        (clk),
        .rst_n      (rst_n),
        .element    (element_ch),
        .result     (result_ch),
        .fail_count (fail_count),
        .pending    (pending)
    );

    always #5 clk = ~clk;

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
    end

    // Abandon a run that hangs
    initial
    begin
        wait (cycle_count >= CLOCK_LIMIT);
        $display("CHECKS FAILED");
        $finish;
    end

    // Stall the result side in random bursts while stalls are enabled
    always @(negedge clk)
    begin
        if (ready_hold > 0)
        begin
            ready_hold--;
            result_ch.ready = 1'b0;
        end
        else if (stalls_on && $urandom_range(0, 5) == 0)
        begin
            ready_hold      = $urandom_range(1, 12) - 1;
            result_ch.ready = 1'b0;
        end
        else
        begin
            result_ch.ready = 1'b1;
        end
    end

    // Present one element, with an optional gap first, and hold it until its transfer
    task automatic push_element(input logic [ssm_pkg::VALUE_W-1:0] v, input logic is_last);
        int gap;

        if (stalls_on && $urandom_range(0, 5) == 0)
        begin
            gap = $urandom_range(1, 12);
            element_ch.valid = 1'b0;
            repeat (gap) @(negedge clk);
        end
        element_ch.valid = 1'b1;
        element_ch.value = v;
        element_ch.last  = is_last;
        do
            @(posedge clk);
        while (!element_ch.ready);
        @(negedge clk);
        items_sent++;
    endtask

    // Send one array of len elements drawn from a window of pool values
    task automatic send_array(input int len, input int pool);
        int base;

        base = $urandom_range(0, ssm_pkg::VALUE_RANGE - 1);
        for (int k = 0; k < len; k++)
        begin
            push_element(ssm_pkg::VALUE_W'((base + $urandom_range(0, pool - 1))
                                           % ssm_pkg::VALUE_RANGE),
                         k == len - 1);
        end
    endtask

    // Pick a random length and value spread, mostly short arrays with repeats
    task automatic random_array();
        int len;
        int pool;

        if ($urandom_range(0, 3) == 0)
        begin
            len = $urandom_range(1, 3);
        end
        else
        begin
            len = $urandom_range(4, 40);
        end
        case ($urandom_range(0, 2))
            0:       pool = $urandom_range(1, 4);
            1:       pool = $urandom_range(1, len);
            default: pool = ssm_pkg::VALUE_RANGE;
        endcase
        send_array(len, pool);
    endtask

    initial
    begin
        rst_n            = 1'b0;
        element_ch.valid = 1'b0;
        element_ch.value = '0;
        element_ch.last  = 1'b0;
        result_ch.ready  = 1'b0;
        stalls_on        = 1'b1;
        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Single-element arrays at both ends of the value range
        push_element(10'd0, 1'b1);
        push_element(10'd1023, 1'b1);
        // One value repeated
        push_element(10'd5, 1'b0);
        push_element(10'd5, 1'b0);
        push_element(10'd5, 1'b1);
        // Equal counts, later value with the shorter span
        push_element(10'd7, 1'b0);
        push_element(10'd9, 1'b0);
        push_element(10'd7, 1'b0);
        push_element(10'd3, 1'b0);
        push_element(10'd3, 1'b1);
        // All distinct
        push_element(10'd0, 1'b0);
        push_element(10'd1023, 1'b0);
        push_element(10'd512, 1'b0);
        push_element(10'd341, 1'b0);
        push_element(10'd682, 1'b1);
        // Alternating bit patterns
        push_element(10'd341, 1'b0);
        push_element(10'd682, 1'b0);
        push_element(10'd341, 1'b0);
        push_element(10'd682, 1'b0);
        push_element(10'd341, 1'b1);

        // Random arrays
        while (items_sent < 340)
        begin
            random_array();
        end
        // Many tiny arrays to run the table epoch round and force a sweep
        repeat (260) send_array($urandom_range(1, 2), 2);

        // Closing stretch at full rate on both sides
        stalls_on   = 1'b0;
        tail_target = items_sent + 80;
        while (items_sent < tail_target)
        begin
            random_array();
        end
        element_ch.valid = 1'b0;

        wait (pending == 0);
        repeat (20) @(posedge clk);
        if (fail_count == 0)
        begin
            $display("ALL CHECKS PASSED");
        end
        else
        begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

endmodule
